[design/sfcc_pkg.sv]
// Shared types, constants and the CRC-8 step for the sensor frame checker.
// No dependencies; the modules and the testbench import this package.
`timescale 1ns / 1ps

package sfcc_pkg;

  // CRC-8: x^8+x^5+x^4+1, seed 0xFF, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte slots within a six-byte frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Scaling: floor(SPAN * raw / 65535), temperature then offset
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // One complete frame, handed from the assembler to the scaler
  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_crc_ok;
    logic        hum_crc_ok;
  } frame_t;

  // Assembler status seen by the top level
  typedef struct packed {
    logic   push;
    logic [2:0] pos;
  } front_stat_t;

  // Advance a CRC-8 over one byte, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[design/sfcc_in_if.sv]
// Byte input channel: valid/ready handshake carrying one frame byte.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

[design/sfcc_out_if.sv]
// Result channel: valid/ready handshake carrying raw words, scaled values, CRC flags.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] temp_raw;
  logic        [15:0] hum_raw;
  logic signed [14:0] temp_centi;
  logic        [13:0] hum_centi;
  logic               temp_crc_ok;
  logic               hum_crc_ok;

  modport source (output valid, output temp_raw, output hum_raw, output temp_centi,
                  output hum_centi, output temp_crc_ok, output hum_crc_ok, input ready);
  modport sink   (input valid, input temp_raw, input hum_raw, input temp_centi,
                  input hum_centi, input temp_crc_ok, input hum_crc_ok, output ready);
endinterface

[design/sfcc_front.sv]
// Frame assembler: tracks byte position, runs CRC-8, builds words, emits a frame.
// Depends on sfcc_pkg.
`timescale 1ns / 1ps

module sfcc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  output sfcc_pkg::frame_t     frame_o,
  output sfcc_pkg::front_stat_t stat_o
);
  import sfcc_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_seed, crc_next;
  logic [15:0] temp_q, temp_d;
  logic [15:0] hum_q, hum_d;
  logic        tok_q, tok_d;
  logic        push;

  // Pick the slot of this byte; a start mark restarts the frame
  always_comb begin
    pos = frame_start_i ? POS_T_MSB : pos_q;
    if (pos > POS_H_CRC) begin
      pos = POS_T_MSB;
    end
  end

  // First byte of each word starts from the seed
  assign crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_q;
  assign crc_next = crc8_byte(crc_seed, rx_byte_i);

  // Update words, CRC and flag by slot
  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    temp_d = temp_q;
    hum_d  = hum_q;
    tok_d  = tok_q;
    push   = 1'b0;
    if (accept_i) begin
      pos_d = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
      unique case (pos)
        POS_T_MSB: begin
          crc_d  = crc_next;
          temp_d = {rx_byte_i, 8'h00};
        end
        POS_T_LSB: begin
          crc_d  = crc_next;
          temp_d = {temp_q[15:8], rx_byte_i};
        end
        POS_T_CRC: begin
          tok_d = (crc_q == rx_byte_i);
          crc_d = CRC_INIT;
        end
        POS_H_MSB: begin
          crc_d = crc_next;
          hum_d = {rx_byte_i, 8'h00};
        end
        POS_H_LSB: begin
          crc_d = crc_next;
          hum_d = {hum_q[15:8], rx_byte_i};
        end
        default: begin
          crc_d = CRC_INIT;
          push  = 1'b1;
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_T_MSB;
      crc_q  <= CRC_INIT;
      temp_q <= 16'h0000;
      hum_q  <= 16'h0000;
      tok_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      tok_q  <= tok_d;
    end
  end

  // Complete frame goes out with the last byte
  assign frame_o.temp_raw    = temp_q;
  assign frame_o.hum_raw     = hum_d;
  assign frame_o.temp_crc_ok = tok_q;
  assign frame_o.hum_crc_ok  = (crc_q == rx_byte_i);

  assign stat_o.push = push;
  assign stat_o.pos  = pos_q;

endmodule

[design/sfcc_queue.sv]
// Short frame queue between assembler and scaler.
// Depends on sfcc_pkg.
`timescale 1ns / 1ps

module sfcc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfcc_pkg::frame_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sfcc_pkg::frame_t rdata_o
);
  import sfcc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  frame_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[design/sfcc_scale.sv]
// Scaler: multiply by span, divide by 65535 via reciprocal estimate and correction.
// Depends on sfcc_pkg.
`timescale 1ns / 1ps

module sfcc_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sfcc_pkg::frame_t    frame_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic         [15:0] temp_raw_o,
  output logic         [15:0] hum_raw_o,
  output logic signed  [14:0] temp_centi_o,
  output logic         [13:0] hum_centi_o,
  output logic                temp_crc_ok_o,
  output logic                hum_crc_ok_o
);
  import sfcc_pkg::*;

  logic        en;
  // stage 1: products
  logic        s1_vld_q;
  frame_t      s1_frm_q;
  logic [30:0] s1_tx_q;
  logic [29:0] s1_hx_q;
  // stage 2: quotient estimates, low product bits for the remainder
  logic        s2_vld_q;
  frame_t      s2_frm_q;
  logic [16:0] s2_tx_q;
  logic [16:0] s2_hx_q;
  logic [14:0] s2_tq_q;
  logic [13:0] s2_hq_q;
  // estimate and correction
  logic [30:0] t_sum;
  logic [29:0] h_sum;
  logic [16:0] t_rem, h_rem;
  logic [14:0] t_fin;
  logic [13:0] h_fin;
  // output register
  logic        out_vld_q;

  // Move the whole pipe when the output slot frees up
  assign en    = !out_vld_q || ready_i;
  assign pop_o = valid_i && en;

  // Estimate q = (x + x/65536) / 65536, never above the true quotient
  assign t_sum = s1_tx_q + (s1_tx_q >> 16);
  assign h_sum = s1_hx_q + (s1_hx_q >> 16);

  // Remainder x - 65535*q, exact in 17 bits; one step up when it reaches 65535
  assign t_rem = s2_tx_q - {s2_tq_q[0], 16'h0000} + {2'b00, s2_tq_q};
  assign h_rem = s2_hx_q - {s2_hq_q[0], 16'h0000} + {3'b000, s2_hq_q};
  assign t_fin = s2_tq_q + {14'd0, (t_rem >= FULL_SCALE)};
  assign h_fin = s2_hq_q + {13'd0, (h_rem >= FULL_SCALE)};

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_frm_q <= frame_i;
      s1_tx_q  <= 31'(frame_i.temp_raw) * 31'(TEMP_SPAN);
      s1_hx_q  <= 30'(frame_i.hum_raw) * 30'(HUM_SPAN);

      s2_frm_q <= s1_frm_q;
      s2_tx_q  <= s1_tx_q[16:0];
      s2_hx_q  <= s1_hx_q[16:0];
      s2_tq_q  <= t_sum[30:16];
      s2_hq_q  <= h_sum[29:16];

      temp_raw_o    <= s2_frm_q.temp_raw;
      hum_raw_o     <= s2_frm_q.hum_raw;
      temp_centi_o  <= $signed(t_fin - TEMP_OFFSET);
      hum_centi_o   <= h_fin;
      temp_crc_ok_o <= s2_frm_q.temp_crc_ok;
      hum_crc_ok_o  <= s2_frm_q.hum_crc_ok;
    end
  end

  assign valid_o = out_vld_q;

endmodule

[design/sensor_frame_crc_check_and_scale_core.sv]
// Top level: frame assembler, frame queue and scaler wired to two handshake channels.
// Depends on sfcc_pkg, sfcc_in_if, sfcc_out_if, sfcc_front, sfcc_queue, sfcc_scale.
//
//   channel | dir | payload                                          | handshake
//   rx_i    | in  | rx_byte, frame_start                             | valid/ready
//   res_o   | out | temp_raw, hum_raw, temp_centi, hum_centi, flags  | valid/ready
//
// One byte is taken per cycle while the frame queue has room; after the sixth byte is
// taken, a result passes the queue slot, product, estimate and output registers.
// The scaler holds its three stages together while the result is not taken;
// the assembler stalls only when the frame queue (QUEUE_DEPTH entries) is full.
// Reset is asynchronous, active low; it puts the byte position at frame start.
`timescale 1ns / 1ps

module sensor_frame_crc_check_and_scale_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfcc_in_if.sink           rx_i,
  sfcc_out_if.source        res_o
);
  import sfcc_pkg::*;

  frame_t      frame;
  frame_t      q_head;
  front_stat_t front_stat;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        accept;

  // Accept bytes while the queue has room
  assign rx_i.ready = !q_full;
  assign accept     = rx_i.valid && !q_full;

  sfcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_i.rx_byte),
    .frame_start_i (rx_i.frame_start),
    .frame_o       (frame),
    .stat_o        (front_stat)
  );

  sfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_stat.push),
    .wdata_i (frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  sfcc_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .frame_i       (q_head),
    .pop_o         (q_pop),
    .valid_o       (res_o.valid),
    .ready_i       (res_o.ready),
    .temp_raw_o    (res_o.temp_raw),
    .hum_raw_o     (res_o.hum_raw),
    .temp_centi_o  (res_o.temp_centi),
    .hum_centi_o   (res_o.hum_centi),
    .temp_crc_ok_o (res_o.temp_crc_ok),
    .hum_crc_ok_o  (res_o.hum_crc_ok)
  );

`ifndef ASSERT_OFF
  // A start-marked byte always leaves the assembler at the second slot
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_i.valid && rx_i.ready && rx_i.frame_start) |=> (front_stat.pos == POS_T_LSB))
    else $error("frame start did not restart byte position");

  // A frame enters the queue only with an accepted byte and never when full
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.push |-> (rx_i.valid && rx_i.ready && !q_full))
    else $error("frame pushed without accepted byte or into full queue");

  // Scaled humidity never exceeds full scale
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hum_centi <= 14'd10000))
    else $error("humidity out of range");
`endif

endmodule

[bench/sensor_frame_crc_check_and_scale_core_tb.sv]
// Testbench for the sensor frame checker: drives frame bytes with random gaps and checks
// every result against a directed table entry or an in-bench frame predictor.
// Depends on sfcc_pkg, sfcc_in_if, sfcc_out_if and sensor_frame_crc_check_and_scale_core.
`timescale 1ns / 1ps

module sensor_frame_crc_check_and_scale_core_tb;
  import sfcc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned T_SPAN       = 17500;
  localparam int unsigned H_SPAN       = 10000;
  localparam int unsigned RAW_FULL     = 65535;
  localparam int          T_OFFSET     = 4500;

  // One expected or observed reading
  typedef struct packed {
    logic        [15:0] temp_raw;
    logic        [15:0] hum_raw;
    logic signed [14:0] temp_centi;
    logic        [13:0] hum_centi;
    logic               temp_ok;
    logic               hum_ok;
  } reading_t;

  // One row of the directed table; a typed reading applies to the frame's last byte
  typedef struct {
    logic [7:0] rx_byte;
    logic       start;
    bit         typed;
    reading_t   want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  sfcc_in_if  rx_if ();
  sfcc_out_if res_if ();

  sensor_frame_crc_check_and_scale_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .res_o  (res_if.source)
  );

  // Predictor state, starting from the reset values
  logic [2:0]  slot      = POS_T_MSB;
  logic [7:0]  acc_crc   = CRC_INIT;
  logic [15:0] t_word    = 16'h0000;
  logic [15:0] h_word    = 16'h0000;
  logic        t_match   = 1'b0;

  reading_t    readings_due [$];
  stim_row_t   dir_rows [$];
  int unsigned errors    = 0;
  int unsigned n_bytes   = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad_crc = 0;
  int unsigned n_cut     = 0;
  bit          send_idle = 1'b1;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // CRC-8 advanced one bit at a time, MSB first
  function automatic logic [7:0] crc8_advance(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_of_word(input logic [15:0] w);
    return crc8_advance(crc8_advance(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Bias data words toward the extremes of the range
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic reading_t mk_reading(input logic [15:0] tr, input logic [15:0] hr,
                                          input int tc, input int hc,
                                          input logic tok, input logic hok);
    reading_t r;
    r.temp_raw   = tr;
    r.hum_raw    = hr;
    r.temp_centi = 15'(tc);
    r.hum_centi  = 14'(hc);
    r.temp_ok    = tok;
    r.hum_ok     = hok;
    return r;
  endfunction

  // Advance the frame predictor by one accepted byte
  task automatic frame_step(input logic [7:0] b, input logic s,
                            output bit got, output reading_t r);
    logic [2:0]  at;
    int unsigned t;
    int unsigned h;
    got = 1'b0;
    r   = '0;
    at  = s ? POS_T_MSB : slot;
    if (at > POS_H_CRC) at = POS_T_MSB;
    case (at)
      POS_T_MSB: begin
        acc_crc = crc8_advance(CRC_INIT, b);
        t_word  = {b, 8'h00};
      end
      POS_T_LSB: begin
        acc_crc     = crc8_advance(acc_crc, b);
        t_word[7:0] = b;
      end
      POS_T_CRC: begin
        t_match = (acc_crc == b);
        acc_crc = CRC_INIT;
      end
      POS_H_MSB: begin
        acc_crc = crc8_advance(CRC_INIT, b);
        h_word  = {b, 8'h00};
      end
      POS_H_LSB: begin
        acc_crc     = crc8_advance(acc_crc, b);
        h_word[7:0] = b;
      end
      default: begin
        t = (T_SPAN * t_word) / RAW_FULL;
        h = (H_SPAN * h_word) / RAW_FULL;
        r = mk_reading(t_word, h_word, int'(t) - T_OFFSET, int'(h), t_match, acc_crc == b);
        acc_crc = CRC_INIT;
        got     = 1'b1;
      end
    endcase
    slot = (at >= POS_H_CRC) ? POS_T_MSB : at + 3'd1;
  endtask

  // Offer one byte after a random gap, hold it until taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic s,
                           input bit typed, input reading_t want);
    int unsigned gap;
    bit          got;
    reading_t    r;
    gap = send_idle ? $urandom_range(12, 0) : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid       <= 1'b1;
    rx_if.rx_byte     <= b;
    rx_if.frame_start <= s;
    do @(posedge clk_i); while (!rx_if.ready);
    n_bytes++;
    frame_step(b, s, got, r);
    if (got) readings_due.push_back(typed ? want : r);
  endtask

  task automatic add_row(input logic [7:0] b, input logic s, input bit typed,
                         input reading_t want);
    stim_row_t row;
    row.rx_byte = b;
    row.start   = s;
    row.typed   = typed;
    row.want    = want;
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string what, input int e, input int a);
    if (e != a) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, e, a);
    end
  endtask

  // Result side: random hold-off before each item, with calm stretches
  initial begin
    int unsigned gap;
    bit          recv_idle;
    recv_idle    = 1'b1;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(15, 0) == 0) recv_idle = !recv_idle;
      gap = recv_idle ? $urandom_range(12, 0) : 0;
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Compare each accepted result with the oldest expected reading
  always @(posedge clk_i) begin
    reading_t seen;
    reading_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = mk_reading(res_if.temp_raw, res_if.hum_raw, int'(res_if.temp_centi),
                        int'(res_if.hum_centi), res_if.temp_crc_ok, res_if.hum_crc_ok);
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got temp_raw %0h hum_raw %0h",
                 $time, seen.temp_raw, seen.hum_raw);
      end else begin
        want = readings_due.pop_front();
        n_checked++;
        if (!want.temp_ok || !want.hum_ok) n_bad_crc++;
        check_field("temp_raw", want.temp_raw, seen.temp_raw);
        check_field("hum_raw", want.hum_raw, seen.hum_raw);
        check_field("temp_centi", int'(want.temp_centi), int'(seen.temp_centi));
        check_field("hum_centi", want.hum_centi, seen.hum_centi);
        check_field("temp_crc_ok", want.temp_ok, seen.temp_ok);
        check_field("hum_crc_ok", want.hum_ok, seen.hum_ok);
      end
    end
  end

  // Stimulus: directed table, then mostly well-formed random frames
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned stop_at;
    bit          paused;
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0]  tc;
    logic [7:0]  hc;
    logic        s0;

    rst_ni            = 1'b0;
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = 8'h00;
    rx_if.frame_start = 1'b0;
    paused            = 1'b0;

    // All-zero frame straight after reset, no start mark needed
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h81, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h81, 1'b0, 1'b1, mk_reading(16'h0000, 16'h0000, -4500, 0, 1'b1, 1'b1));
    // Full-scale frame
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hAC, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hAC, 1'b0, 1'b1, mk_reading(16'hFFFF, 16'hFFFF, 13000, 10000, 1'b1, 1'b1));
    // Partial frame cut by a new start, then both checksums wrong
    add_row(8'hBE, 1'b1, 1'b0, '0);
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h7E, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, mk_reading(16'h0000, 16'hFFFF, -4500, 10000, 1'b0, 1'b0));
    // Free-running frame without start marks, humidity checksum off by one
    add_row(8'hBE, 1'b0, 1'b0, '0);
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'h92, 1'b0, 1'b0, '0);
    add_row(8'hBE, 1'b0, 1'b0, '0);
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'h93, 1'b0, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx_byte, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
    end

    stop_at = n_bytes + RANDOM_BYTES;
    while (n_bytes < stop_at) begin
      if ($urandom_range(9, 0) == 0) send_idle = !send_idle;

      // Drain once midway: hold the sender until every reading has come back
      if (!paused && n_bytes > stop_at - RANDOM_BYTES / 2) begin
        rx_if.valid <= 1'b0;
        @(posedge clk_i);
        while (readings_due.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end

      kind = $urandom_range(99, 0);
      if (kind < 70) begin
        // Well-formed frame; mark the start whenever the stream is off alignment
        tw = pick_word();
        hw = pick_word();
        tc = crc_of_word(tw);
        hc = crc_of_word(hw);
        if ($urandom_range(6, 0) == 0) tc ^= 8'($urandom_range(255, 1));
        if ($urandom_range(6, 0) == 0) hc ^= 8'($urandom_range(255, 1));
        s0 = (slot != POS_T_MSB) ? 1'b1 : 1'($urandom_range(1, 0));
        send_byte(tw[15:8], s0, 1'b0, '0);
        send_byte(tw[7:0], 1'b0, 1'b0, '0);
        send_byte(tc, 1'b0, 1'b0, '0);
        send_byte(hw[15:8], 1'b0, 1'b0, '0);
        send_byte(hw[7:0], 1'b0, 1'b0, '0);
        send_byte(hc, 1'b0, 1'b0, '0);
      end else if (kind < 85) begin
        // Truncated frame; the next well-formed one restarts it
        len = $urandom_range(5, 1);
        n_cut++;
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom()), i == 0, 1'b0, '0);
        end
      end else begin
        // Noise with scattered start marks
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom()), $urandom_range(3, 0) == 0, 1'b0, '0);
        end
      end
    end

    rx_if.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes with %0d cut frames; compared %0d readings, %0d with a bad checksum.",
             n_bytes, n_cut, n_checked, n_bad_crc);
    if (errors == 0) begin
      $display("sensor_frame_crc_check_and_scale_core_tb: clean");
    end else begin
      $display("sensor_frame_crc_check_and_scale_core_tb: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Timed out with %0d readings still due.", readings_due.size());
    $display("sensor_frame_crc_check_and_scale_core_tb: errors");
    $finish;
  end

endmodule
